// ===== rtl/quadratic_lowest_root_unit_macros.svh =====
// quadratic_lowest_root_unit_macros.svh: assertion macros for the QLR block.
// No dependencies; included by modules that carry assertions.
`ifndef QUADRATIC_LOWEST_ROOT_UNIT_MACROS_SVH
`define QUADRATIC_LOWEST_ROOT_UNIT_MACROS_SVH
// Implication checked while out of reset.
`define QLR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked while out of reset.
`define QLR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/qlr_pkg.sv =====
// qlr_pkg.sv: shared types and constants for the quadratic lowest root unit.
// No dependencies.
`default_nettype none
package qlr_pkg;
    localparam int FracBitsDef = 16;
    localparam int QueueDepthDef = 4;
    // discriminant and root pipeline widths
    localparam int DiscW = 68;
    localparam int SqrtW = 34;
    localparam int NumW = 36;

    typedef struct packed {
        logic signed [31:0] coef_quad;
        logic signed [31:0] coef_lin;
        logic signed [31:0] coef_const;
        logic signed [31:0] upper_limit;
    } qlr_in_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] root_value;
    } qlr_out_t;

    // classified item passed from front to back
    typedef struct packed {
        logic               skip;
        logic [DiscW-1:0]   disc;
        logic signed [32:0] neg_b;
        logic signed [32:0] two_a;
        logic signed [31:0] upper_limit;
    } qlr_job_t;
endpackage
`default_nettype wire

// ===== rtl/quadratic_lowest_root_unit.sv =====
// quadratic_lowest_root_unit.sv: top level of the quadratic lowest root unit.
// Depends on qlr_pkg, qlr_front, qlr_queue, qlr_back.
// Finds the smallest root of a*x^2+b*x+c strictly inside (0, upper_limit), all
// signed fixed point with FRAC_BITS fraction bits. One request is accepted per
// cycle with no stall unless the result side holds back. An item passes the
// front (multipliers, discriminant), the queue and the back (34 square-root
// bit stages, 36+FRAC_BITS divider bit stages, pipeline registers, output
// register); the divider bit pipeline sets the depth.
// Zero a or a negative discriminant gives found=0, root_value=0.
`default_nettype none
module quadratic_lowest_root_unit import qlr_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire qlr_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output qlr_out_t     m_data
);
    logic     fj_valid, fj_ready, bj_valid, bj_ready;
    qlr_job_t fj, bj;

    qlr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    qlr_queue #(.Depth(QueueDepthDef)) u_queue (
        .aclk, .aresetn,
        .w_valid(fj_valid), .w_ready(fj_ready), .w_data(fj),
        .r_valid(bj_valid), .r_ready(bj_ready), .r_data(bj)
    );

    qlr_back #(.FracBits(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .j_valid(bj_valid), .j_ready(bj_ready), .j_data(bj),
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

// ===== rtl/qlr_front.sv =====
// qlr_front.sv: accepts items, forms the exact discriminant, flags skips.
// Depends on qlr_pkg.
`default_nettype none
module qlr_front import qlr_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire qlr_in_t  s_data,
    output logic          job_valid,
    input  wire logic     job_ready,
    output qlr_job_t      job
);
    // stage 1: products (two 32x32 multipliers)
    logic               v1_reg, v1_next;
    logic [63:0]        b2_reg, m_reg;
    logic               acpos_reg, azero_reg;
    logic signed [31:0] a1_reg, b1_reg, lim1_reg;
    // stage 2: discriminant
    logic     v2_reg, v2_next;
    qlr_job_t job_reg;
    logic     adv;
    logic [31:0] ma, mb, mc;
    logic [DiscW-1:0] b2w, m4w, dsub, dadd;

    assign adv       = !v2_reg || job_ready;
    assign s_ready   = adv;
    assign job_valid = v2_reg;
    assign job       = job_reg;
    assign v1_next   = s_valid;
    assign v2_next   = v1_reg;

    assign ma = s_data.coef_quad[31]  ? 32'(-s_data.coef_quad)  : 32'(s_data.coef_quad);
    assign mb = s_data.coef_lin[31]   ? 32'(-s_data.coef_lin)   : 32'(s_data.coef_lin);
    assign mc = s_data.coef_const[31] ? 32'(-s_data.coef_const) : 32'(s_data.coef_const);

    assign b2w  = {{(DiscW-64){1'b0}}, b2_reg};
    assign m4w  = {{(DiscW-66){1'b0}}, m_reg, 2'b00};
    assign dsub = b2w - m4w;
    assign dadd = b2w + m4w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
        if (adv) begin
            b2_reg    <= 64'(mb) * 64'(mb);
            m_reg     <= 64'(ma) * 64'(mc);
            acpos_reg <= (s_data.coef_quad != 0) && (s_data.coef_const != 0)
                         && (s_data.coef_quad[31] == s_data.coef_const[31]);
            azero_reg <= (s_data.coef_quad == 0);
            a1_reg    <= s_data.coef_quad;
            b1_reg    <= s_data.coef_lin;
            lim1_reg  <= s_data.upper_limit;
            // negative discriminant or zero a: nothing to find
            job_reg.skip  <= azero_reg || (acpos_reg && (m4w > b2w));
            job_reg.disc  <= acpos_reg ? dsub : dadd;
            job_reg.neg_b <= -33'(b1_reg);
            job_reg.two_a <= 33'(a1_reg) <<< 1;
            job_reg.upper_limit <= lim1_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/qlr_queue.sv =====
// qlr_queue.sv: small FIFO decoupling front and back.
// Depends on qlr_pkg.
`default_nettype none
module qlr_queue import qlr_pkg::*; #(
    parameter int Depth = QueueDepthDef
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     w_valid,
    output logic          w_ready,
    input  wire qlr_job_t w_data,
    output logic          r_valid,
    input  wire logic     r_ready,
    output qlr_job_t      r_data
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    qlr_job_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic wr, rd;

    assign w_ready = (cnt_reg != (AW+1)'(Depth));
    assign r_valid = (cnt_reg != '0);
    assign r_data  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        if (wr) wp_next = (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
        if (rd) rp_next = (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
        cnt_next = cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (wr) mem_reg[wp_reg] <= w_data;
    end

`include "quadratic_lowest_root_unit_macros.svh"
    `QLR_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(Depth), "queue over")
    `QLR_ASSERT_NXT(a_cnt_up, aclk, aresetn, wr && !rd, cnt_reg == $past(cnt_reg) + 1'b1, "cnt")
    `QLR_ASSERT_NXT(a_cnt_dn, aclk, aresetn, rd && !wr, cnt_reg == $past(cnt_reg) - 1'b1, "cnt")
endmodule
`default_nettype wire

// ===== rtl/qlr_back.sv =====
// qlr_back.sv: pipelined square root, two pipelined dividers, root select.
// Depends on qlr_pkg.
`default_nettype none
module qlr_back import qlr_pkg::*; #(
    parameter int FracBits = FracBitsDef
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     j_valid,
    output logic          j_ready,
    input  wire qlr_job_t j_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output qlr_out_t      m_data
);
    localparam int SqSt = SqrtW;          // one result bit per stage
    localparam int QW   = NumW + FracBits; // quotient bits
    localparam int DvW  = QW;              // dividend width
    localparam int DsW  = 33;              // |2a| width

    // square root pipe: stage k resolves one bit
    typedef struct packed {
        logic               skip;
        logic [DiscW+1:0]   rem;
        logic [SqrtW-1:0]   root;
        logic signed [32:0] neg_b;
        logic signed [32:0] two_a;
        logic signed [31:0] lim;
    } sq_t;

    typedef struct packed {
        logic               skip;
        logic [DvW-1:0]     q1;
        logic [DvW-1:0]     q2;
        logic [DvW-1:0]     n1;
        logic [DvW-1:0]     n2;
        logic [DvW:0]       r1;
        logic [DvW:0]       r2;
        logic               neg1;
        logic               neg2;
        logic [DsW-1:0]     den;
        logic signed [31:0] lim;
    } dv_t;

    localparam int NSt = SqSt + 1 + QW + 1;
    logic [NSt-1:0] v_reg;
    logic           adv;
    sq_t sq_reg [SqSt+1];
    dv_t dv_reg [QW+1];
    qlr_out_t out_reg;
    logic     out_v_reg;

    assign adv     = !out_v_reg || m_ready;
    assign j_ready = adv;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg     <= {v_reg[NSt-2:0], j_valid};
            out_v_reg <= v_reg[NSt-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0].skip  <= j_data.skip;
            sq_reg[0].rem   <= {2'b00, j_data.disc};
            sq_reg[0].root  <= '0;
            sq_reg[0].neg_b <= j_data.neg_b;
            sq_reg[0].two_a <= j_data.two_a;
            sq_reg[0].lim   <= j_data.upper_limit;
        end
    end

    // digit-by-digit floor sqrt, radix-2 restoring, one bit per stage
    for (genvar k = 0; k < SqSt; k++) begin : g_sq
        localparam int Sh = 2 * (SqSt - 1 - k);
        logic [DiscW+1:0] trial;
        logic             take;
        sq_t              nx;
        always_comb begin
            trial = ({{(DiscW+2-SqrtW){1'b0}}, sq_reg[k].root} << (Sh + 2))
                    | ((DiscW+2)'(1) << Sh);
            take  = sq_reg[k].rem >= trial;
            nx      = sq_reg[k];
            nx.rem  = take ? sq_reg[k].rem - trial : sq_reg[k].rem;
            nx.root = {sq_reg[k].root[SqrtW-2:0], take};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[k+1] <= nx;
            end
        end
    end

    // numerators and signs
    logic signed [NumW-1:0] num1, num2, sv;
    logic [NumW-1:0]        mag1, mag2;
    always_comb begin
        sv   = NumW'($signed({1'b0, sq_reg[SqSt].root}));
        num1 = NumW'(sq_reg[SqSt].neg_b) - sv;
        num2 = NumW'(sq_reg[SqSt].neg_b) + sv;
        mag1 = num1[NumW-1] ? NumW'(-num1) : NumW'(num1);
        mag2 = num2[NumW-1] ? NumW'(-num2) : NumW'(num2);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0].skip <= sq_reg[SqSt].skip;
            dv_reg[0].n1   <= DvW'(mag1) << FracBits;
            dv_reg[0].n2   <= DvW'(mag2) << FracBits;
            dv_reg[0].q1   <= '0;
            dv_reg[0].q2   <= '0;
            dv_reg[0].r1   <= '0;
            dv_reg[0].r2   <= '0;
            dv_reg[0].neg1 <= num1[NumW-1] != sq_reg[SqSt].two_a[32];
            dv_reg[0].neg2 <= num2[NumW-1] != sq_reg[SqSt].two_a[32];
            dv_reg[0].den  <= sq_reg[SqSt].two_a[32] ? DsW'(-sq_reg[SqSt].two_a)
                                                     : DsW'(sq_reg[SqSt].two_a);
            dv_reg[0].lim  <= sq_reg[SqSt].lim;
        end
    end

    // restoring long division, one quotient bit per stage, both roots
    for (genvar k = 0; k < QW; k++) begin : g_dv
        logic [DvW:0] t1, t2;
        logic         g1, g2;
        dv_t          nx;
        always_comb begin
            t1 = {dv_reg[k].r1[DvW-1:0], dv_reg[k].n1[DvW-1]};
            t2 = {dv_reg[k].r2[DvW-1:0], dv_reg[k].n2[DvW-1]};
            g1 = t1 >= (DvW+1)'(dv_reg[k].den);
            g2 = t2 >= (DvW+1)'(dv_reg[k].den);
            nx    = dv_reg[k];
            nx.n1 = dv_reg[k].n1 << 1;
            nx.n2 = dv_reg[k].n2 << 1;
            nx.r1 = g1 ? t1 - (DvW+1)'(dv_reg[k].den) : t1;
            nx.r2 = g2 ? t2 - (DvW+1)'(dv_reg[k].den) : t2;
            nx.q1 = {dv_reg[k].q1[DvW-2:0], g1};
            nx.q2 = {dv_reg[k].q2[DvW-2:0], g2};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[k+1] <= nx;
            end
        end
    end

    // final select: signed roots, order, range test
    logic signed [DvW:0] ra, rb, lo, hi, limw;
    logic                lo_ok, hi_ok;
    always_comb begin
        ra   = dv_reg[QW].neg1 ? -$signed({1'b0, dv_reg[QW].q1})
                               :  $signed({1'b0, dv_reg[QW].q1});
        rb   = dv_reg[QW].neg2 ? -$signed({1'b0, dv_reg[QW].q2})
                               :  $signed({1'b0, dv_reg[QW].q2});
        lo   = (ra > rb) ? rb : ra;
        hi   = (ra > rb) ? ra : rb;
        limw = (DvW+1)'(dv_reg[QW].lim);
        lo_ok = (lo > 0) && (lo < limw);
        hi_ok = (hi > 0) && (hi < limw);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.found      <= !dv_reg[QW].skip && (lo_ok || hi_ok);
            out_reg.root_value <= dv_reg[QW].skip ? 32'sd0 :
                                  lo_ok ? 32'(lo) : hi_ok ? 32'(hi) : 32'sd0;
        end
    end

`include "quadratic_lowest_root_unit_macros.svh"
    `QLR_ASSERT_IMP(a_nf_zero, aclk, aresetn, m_valid && !m_data.found, m_data.root_value == 0, "nf val")
    `QLR_ASSERT_IMP(a_f_pos, aclk, aresetn, m_valid && m_data.found, m_data.root_value > 0, "root sign")
    `QLR_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "hold")
endmodule
`default_nettype wire

// ===== bench/qlr_checker.sv =====
// qlr_checker.sv: watches both channels of the quadratic lowest root unit,
// predicts each result from the request and compares. Depends on qlr_pkg.
module qlr_checker import qlr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  qlr_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  qlr_out_t m_data,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    qlr_out_t root_q[$];

    // floor square root of a 68-bit value, bit by bit
    function automatic logic [33:0] floor_sqrt(input logic [67:0] v);
        logic [67:0] rem;
        logic [67:0] res;
        logic [67:0] bitv;
        rem = v;
        res = '0;
        bitv = 68'd1 << 66;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[33:0];
    endfunction

    // trunc(n * 2^16 / d), toward zero
    function automatic logic signed [63:0] fix_quot(input logic signed [63:0] n,
                                                    input logic signed [63:0] d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] uq;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        uq = (un << 16) / ud;
        return ((n < 0) != (d < 0)) ? -$signed(uq) : $signed(uq);
    endfunction

    function automatic qlr_out_t lowest_root(input qlr_in_t r);
        logic signed [127:0] a, b, c, lim, disc, s, r1, r2, t;
        qlr_out_t o;
        o = '0;
        a = r.coef_quad;
        b = r.coef_lin;
        c = r.coef_const;
        lim = r.upper_limit;
        disc = b * b - 4 * a * c;
        if (a == 0 || disc < 0) return o;
        s = floor_sqrt(disc[67:0]);
        r1 = fix_quot(64'(-b - s), 64'(2 * a));
        r2 = fix_quot(64'(-b + s), 64'(2 * a));
        if (r1 > r2) begin
            t = r1; r1 = r2; r2 = t;
        end
        if (r1 > 0 && r1 < lim) begin
            o.found = 1'b1;
            o.root_value = r1[31:0];
        end else if (r2 > 0 && r2 < lim) begin
            o.found = 1'b1;
            o.root_value = r2[31:0];
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        qlr_out_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                root_q.push_back(lowest_root(s_data));
            if (m_valid && m_ready) begin
                if (root_q.size() == 0) begin
                    $error("unexpected result %0d/%0h", m_data.found, m_data.root_value);
                    errs++;
                end else begin
                    want = root_q.pop_front();
                    if (want.found !== m_data.found) begin
                        $error("found: expected %0d actual %0d", want.found, m_data.found);
                        errs++;
                    end
                    if (want.root_value !== m_data.root_value) begin
                        $error("root_value: expected %0h actual %0h",
                               want.root_value, m_data.root_value);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= root_q.size();
    end
endmodule

// ===== bench/tb_quadratic_lowest_root_unit.sv =====
// tb_quadratic_lowest_root_unit.sv: stimulus and verdict for the quadratic
// lowest root unit. Depends on qlr_pkg, qlr_checker and the RTL.
module tb_quadratic_lowest_root_unit;
    import qlr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    qlr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    qlr_out_t m_data;
    int       fail_count;
    int       pending;
    int       sent = 0;

    always #1 aclk = ~aclk;

    quadratic_lowest_root_unit dut (.*);

    qlr_checker u_chk (.*);

    // Global watchdog: 1000+ requests with random gaps
    initial begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side stalls: random hold-off per result, with calm stretches.
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            repeat (w) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Present one request and hold it until accepted; valid drops only for a gap.
    task automatic send_req(input logic signed [31:0] a, b, c, lim);
        int w;
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (w != 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{a, b, c, lim};
        @(posedge aclk iff s_ready);
        sent++;
    endtask

    // Well-formed request: roots r1,r2 chosen in small range, a*(x-r1)(x-r2).
    task automatic send_roots();
        longint r1, r2, a, b, c;
        a = $signed($urandom_range(1, 4 * ONE)) * ($urandom_range(0, 1) ? 1 : -1);
        r1 = $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
        r2 = $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
        b = -(a * (r1 + r2)) >>> 16;
        c = ((a * r1) >>> 16) * r2 >>> 16;
        send_req(32'(a), 32'(b), 32'(c), 32'($urandom_range(0, 30 * ONE)));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: zero a, negative discriminant, double root, extremes
        send_req(0, ONE, -ONE, MAXV);
        send_req(ONE, 0, ONE, MAXV);
        send_req(ONE, -2 * ONE, ONE, MAXV);
        send_req(ONE, -3 * ONE, 2 * ONE, MAXV);
        send_req(ONE, -3 * ONE, 2 * ONE, 2 * ONE);
        send_req(ONE, -3 * ONE, 2 * ONE, ONE);
        send_req(-ONE, 3 * ONE, -2 * ONE, MAXV);
        send_req(ONE, ONE, -2 * ONE, MAXV);
        send_req(MAXV, MAXV, MAXV, MAXV);
        send_req(MINV, MINV, MINV, MINV);
        send_req(MINV, MAXV, MINV, MAXV);
        send_req(MAXV, MINV, MINV, MAXV);
        send_req(1, MINV, 0, MAXV);
        send_req(-1, MAXV, MAXV, MAXV);
        send_req(1, 0, MINV, MAXV);
        send_req(-1, 0, MAXV, MAXV);
        send_req(ONE, 0, 0, MAXV);
        send_req(ONE, -ONE, 0, -ONE);
        // random: mostly real-root cases, the rest raw noise
        repeat (1000) begin
            if ($urandom_range(0, 9) < 7)
                send_roots();
            else
                send_req($urandom, $urandom, $urandom, $urandom);
        end
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/qlr_pkg.sv
rtl/qlr_front.sv
rtl/qlr_queue.sv
rtl/qlr_back.sv
rtl/quadratic_lowest_root_unit.sv
bench/qlr_checker.sv
bench/tb_quadratic_lowest_root_unit.sv
